### hdl/nwc_pkg.sv
// Shared types and constants for the normalized window convolution core.
// No dependencies; used by every module in hdl/.
`default_nettype none

package nwc_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_KERNEL = 3;
	localparam int MAX_HEIGHT     = 4096;

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int KSIZE_W  = 2;
	localparam int COEF_W   = 16;
	localparam int ROWC_W   = 3 * COEF_W;
	localparam int ROW_W    = 12;
	localparam int COL_W    = 10;
	localparam int PIX_W    = 8;

	// products, sums and the serial divide
	localparam int PROD_W = PIX_W + 1 + COEF_W;
	localparam int SUM_W  = 28;
	localparam int CSUM_W = 20;
	localparam int NUM_W  = SUM_W + 8;
	localparam int DEN_W  = CSUM_W;

	localparam int APB_AW = 6;
	localparam int APB_DW = 64;

	// register indexes, byte address is 8*index
	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_KSIZE  = 3'd2;
	localparam logic [2:0] REG_COEF0  = 3'd3;
	localparam logic [2:0] REG_COEF1  = 3'd4;
	localparam logic [2:0] REG_COEF2  = 3'd5;

	localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(1024);
	localparam logic [KSIZE_W-1:0]  RST_KSIZE  = KSIZE_W'(1);
	localparam logic [ROWC_W-1:0]   RST_COEF0  = ROWC_W'(256);
	localparam logic [ROWC_W-1:0]   RST_COEF1  = '0;
	localparam logic [ROWC_W-1:0]   RST_COEF2  = '0;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               div_by_zero;
		logic [ROW_W-1:0]   out_row;
		logic [COL_W-1:0]   out_col;
		logic               last;
	} out_item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0]       image_width;
		logic [HEIGHT_W-1:0]      image_height;
		logic [KSIZE_W-1:0]       kernel_size;
		logic [2:0][ROWC_W-1:0]   coef_row;
	} cfg_t;

endpackage

`default_nettype wire

### hdl/nwc_regs.sv
// APB-style configuration registers of the convolution core.
// Depends on nwc_pkg.
`default_nettype none

module nwc_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nwc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [nwc_pkg::APB_DW-1:0]    pwdata,
	output logic      [nwc_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	output nwc_pkg::cfg_t                      cfg
);

	nwc_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign idx    = paddr[5:3];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= nwc_pkg::RST_WIDTH;
			cfg_q.image_height <= nwc_pkg::RST_HEIGHT;
			cfg_q.kernel_size  <= nwc_pkg::RST_KSIZE;
			cfg_q.coef_row[0]  <= nwc_pkg::RST_COEF0;
			cfg_q.coef_row[1]  <= nwc_pkg::RST_COEF1;
			cfg_q.coef_row[2]  <= nwc_pkg::RST_COEF2;
		end else if (wr) begin
			unique case (idx)
				nwc_pkg::REG_WIDTH:  cfg_q.image_width  <= pwdata[nwc_pkg::WIDTH_W-1:0];
				nwc_pkg::REG_HEIGHT: cfg_q.image_height <= pwdata[nwc_pkg::HEIGHT_W-1:0];
				nwc_pkg::REG_KSIZE:  cfg_q.kernel_size  <= pwdata[nwc_pkg::KSIZE_W-1:0];
				nwc_pkg::REG_COEF0:  cfg_q.coef_row[0]  <= pwdata[nwc_pkg::ROWC_W-1:0];
				nwc_pkg::REG_COEF1:  cfg_q.coef_row[1]  <= pwdata[nwc_pkg::ROWC_W-1:0];
				nwc_pkg::REG_COEF2:  cfg_q.coef_row[2]  <= pwdata[nwc_pkg::ROWC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			nwc_pkg::REG_WIDTH:  prdata = nwc_pkg::APB_DW'(cfg_q.image_width);
			nwc_pkg::REG_HEIGHT: prdata = nwc_pkg::APB_DW'(cfg_q.image_height);
			nwc_pkg::REG_KSIZE:  prdata = nwc_pkg::APB_DW'(cfg_q.kernel_size);
			nwc_pkg::REG_COEF0:  prdata = nwc_pkg::APB_DW'(cfg_q.coef_row[0]);
			nwc_pkg::REG_COEF1:  prdata = nwc_pkg::APB_DW'(cfg_q.coef_row[1]);
			nwc_pkg::REG_COEF2:  prdata = nwc_pkg::APB_DW'(cfg_q.coef_row[2]);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hdl/nwc_line_store.sv
// Two line stores (rows r-2 and r-1) sharing one address, registered read.
// Depends on nwc_pkg.
`default_nettype none

module nwc_line_store #(
	parameter int DEPTH = nwc_pkg::DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                         clk,
	input  wire logic                         rd_en,
	input  wire logic [AW-1:0]                rd_addr,
	output logic      [nwc_pkg::PIX_W-1:0]    rd_older,
	output logic      [nwc_pkg::PIX_W-1:0]    rd_newer,
	input  wire logic                         wr_en,
	input  wire logic [AW-1:0]                wr_addr,
	input  wire logic [nwc_pkg::PIX_W-1:0]    wr_older,
	input  wire logic [nwc_pkg::PIX_W-1:0]    wr_newer
);

	logic [nwc_pkg::PIX_W-1:0] older_mem [DEPTH];
	logic [nwc_pkg::PIX_W-1:0] newer_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
		if (rd_en) begin
			rd_older <= older_mem[rd_addr];
			rd_newer <= newer_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hdl/nwc_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed and saturated.
// Depends on nwc_pkg.
`default_nettype none

module nwc_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [nwc_pkg::NUM_W-1:0]    num,
	input  wire logic [nwc_pkg::DEN_W-1:0]    den,
	input  wire logic                         neg,
	output logic                              done,
	output logic signed [31:0]                quot
);

	localparam int NW = nwc_pkg::NUM_W;
	localparam int DW = nwc_pkg::DEN_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [NW-1:0]    nq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             fits;

	assign trial = {rem_q, nq_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = !diff[DW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			nq_q  <= {nq_q[NW-2:0], fits};
		end
	end

	// sign and saturate the magnitude
	always_comb begin
		if (neg_q) begin
			if (nq_q > NW'(33'h0_8000_0000))
				quot = 32'sh8000_0000;
			else
				quot = 32'(-nq_q);
		end else begin
			if (nq_q > NW'(32'h7FFF_FFFF))
				quot = 32'sh7FFF_FFFF;
			else
				quot = 32'(nq_q);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

### hdl/normalized_window_convolution_core.sv
// Top level of the normalized window convolution core.
// Depends on nwc_pkg, nwc_regs, nwc_line_store and nwc_divider.
`default_nettype none

// Streams an 8-bit image in raster order and, for each pixel that closes a
// k-by-k window (valid region, no padding), returns the window's weighted sum
// divided by the coefficient sum, truncated toward zero, as signed Q23.8.
// A zero coefficient sum gives value 0 with div_by_zero set. One item is in
// work at a time: a pixel that closes no window passes only the update state,
// and one that closes a window then runs the multiply-accumulate, with the
// single multiplier stepping through the kernel terms, and the one-bit-per-
// cycle divider over a 36-bit dividend. A finished result sits in the output
// register, so the next pixel may be taken while it waits. Configuration goes
// through the APB port at byte address 8*i and is to be written while idle.
// No clearing pass is run after reset; line store entries read before they
// are written give undefined pixels.
module normalized_window_convolution_core #(
	parameter int MAX_WIDTH  = nwc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = nwc_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         pix_valid,
	output logic                              pix_ready,
	input  wire nwc_pkg::in_item_t            pix_data,
	output logic                              res_valid,
	input  wire logic                         res_ready,
	output nwc_pkg::out_item_t                res_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [nwc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [nwc_pkg::APB_DW-1:0]   pwdata,
	output logic      [nwc_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	// wide enough for the width register and for MAX_WIDTH itself
	localparam int WW = (CW + 1 > nwc_pkg::WIDTH_W) ? CW + 1 : nwc_pkg::WIDTH_W;
	localparam int RW = nwc_pkg::ROW_W;
	localparam int HW = nwc_pkg::HEIGHT_W;
	localparam int KW = nwc_pkg::KSIZE_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_UPD   = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_CHK   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_FIN   = 3'd6;

	nwc_pkg::cfg_t cfg;

	nwc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamped geometry
	logic [WW-1:0] wc;
	logic [HW-1:0] hc;
	logic [KW-1:0] kc;

	always_comb begin
		if (cfg.image_width == '0)
			wc = WW'(1);
		else if (WW'(cfg.image_width) > WW'(MAX_WIDTH))
			wc = WW'(MAX_WIDTH);
		else
			wc = WW'(cfg.image_width);

		if (cfg.image_height == '0)
			hc = HW'(1);
		else if (cfg.image_height > HW'(nwc_pkg::MAX_HEIGHT))
			hc = HW'(nwc_pkg::MAX_HEIGHT);
		else
			hc = cfg.image_height;

		if (cfg.kernel_size == '0)
			kc = KW'(1);
		else if (cfg.kernel_size > KW'(MAX_KERNEL))
			kc = KW'(MAX_KERNEL);
		else
			kc = cfg.kernel_size;
	end

	// sequencer and position state
	logic [2:0]    st_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] cur_c_q;
	logic [RW-1:0] cur_r_q;
	logic [nwc_pkg::PIX_W-1:0] px_q;

	logic          accept;
	logic [CW-1:0] c0, cur_c, nxt_c;
	logic [RW-1:0] r0, cur_r, nxt_r;
	logic          col_wrap;

	assign pix_ready = (st_q == ST_IDLE);
	assign accept    = pix_valid && pix_ready;

	// position of the arriving pixel, after frame start and shrink wrap
	always_comb begin
		c0    = pix_data.frame_start ? '0 : col_q;
		r0    = pix_data.frame_start ? '0 : row_q;
		cur_c = (WW'(c0) >= wc) ? '0 : c0;
		cur_r = (HW'(r0) >= hc) ? '0 : r0;
		col_wrap = (WW'(cur_c) + WW'(1) >= wc);
		if (col_wrap) begin
			nxt_c = '0;
			nxt_r = (HW'(cur_r) + HW'(1) >= hc) ? '0 : cur_r + RW'(1);
		end else begin
			nxt_c = cur_c + CW'(1);
			nxt_r = cur_r;
		end
	end

	// line stores
	logic [nwc_pkg::PIX_W-1:0] ls_older, ls_newer;
	logic                      upd;

	assign upd = (st_q == ST_UPD);

	nwc_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_ls (
		.clk      (clk),
		.rd_en    (accept),
		.rd_addr  (cur_c),
		.rd_older (ls_older),
		.rd_newer (ls_newer),
		.wr_en    (upd),
		.wr_addr  (cur_c_q),
		.wr_older (ls_newer),
		.wr_newer (px_q)
	);

	// 3x3 window, [row][col], column 2 newest
	logic [nwc_pkg::PIX_W-1:0] win_q [3][3];

	// multiply-accumulate over the kernel terms
	logic [1:0] xi_q, yi_q;
	logic [1:0] off;
	logic [nwc_pkg::PIX_W-1:0]        pix_sel;
	logic signed [nwc_pkg::COEF_W-1:0] coef_sel;
	logic signed [nwc_pkg::PROD_W-1:0] prod_s1;
	logic signed [nwc_pkg::COEF_W-1:0] cf_s1;
	logic                              pv_s1;
	logic signed [nwc_pkg::SUM_W-1:0]  s_q;
	logic signed [nwc_pkg::CSUM_W-1:0] cs_q;
	logic                              emit;
	logic                              last_term;

	assign off       = 2'd3 - kc;
	assign pix_sel   = win_q[off + xi_q][off + yi_q];
	assign coef_sel  = cfg.coef_row[xi_q][{yi_q, 4'b0000} +: nwc_pkg::COEF_W];
	assign last_term = (xi_q == kc - 2'd1) && (yi_q == kc - 2'd1);
	assign emit      = (HW'(cur_r_q) + HW'(1) >= HW'(kc))
	                && (WW'(cur_c_q) + WW'(1) >= WW'(kc));

	// divide
	logic [nwc_pkg::SUM_W-1:0]  s_mag;
	logic [nwc_pkg::CSUM_W-1:0] cs_mag;
	logic                       div_start;
	logic                       div_done;
	logic signed [31:0]         div_quot;

	assign s_mag     = s_q[nwc_pkg::SUM_W-1] ? nwc_pkg::SUM_W'(-s_q) : s_q;
	assign cs_mag    = cs_q[nwc_pkg::CSUM_W-1] ? nwc_pkg::CSUM_W'(-cs_q) : cs_q;
	assign div_start = (st_q == ST_CHK) && (cs_q != '0);

	nwc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({s_mag, 8'b0}),
		.den    (cs_mag),
		.neg    (s_q[nwc_pkg::SUM_W-1] ^ cs_q[nwc_pkg::CSUM_W-1]),
		.done   (div_done),
		.quot   (div_quot)
	);

	// result holding
	logic signed [31:0]  val_q;
	logic                dz_q;
	logic                res_valid_q;
	nwc_pkg::out_item_t  res_q;
	logic                res_load;
	logic [WW-1:0]       col_o;
	logic [RW-1:0]       row_o;

	assign res_load  = (st_q == ST_FIN) && (!res_valid_q || res_ready);
	assign col_o     = WW'(cur_c_q) + WW'(1) - WW'(kc);
	assign row_o     = cur_r_q + RW'(1) - RW'(kc);
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			res_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
			for (int x = 0; x < 3; x++) begin
				for (int y = 0; y < 3; y++) begin
					win_q[x][y] <= '0;
				end
			end
		end else begin
			pv_s1 <= 1'b0;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;

			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= nxt_c;
						row_q <= nxt_r;
						st_q  <= ST_UPD;
					end
				end
				ST_UPD: begin
					for (int x = 0; x < 3; x++) begin
						win_q[x][0] <= win_q[x][1];
						win_q[x][1] <= win_q[x][2];
					end
					win_q[0][2] <= ls_older;
					win_q[1][2] <= ls_newer;
					win_q[2][2] <= px_q;
					st_q <= emit ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					pv_s1 <= 1'b1;
					if (last_term)
						st_q <= ST_DRAIN;
				end
				ST_DRAIN: st_q <= ST_CHK;
				ST_CHK:   st_q <= (cs_q == '0) ? ST_FIN : ST_DIV;
				ST_DIV: begin
					if (div_done)
						st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_load)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_c_q <= cur_c;
			cur_r_q <= cur_r;
			px_q    <= pix_data.pixel;
		end

		if (st_q == ST_UPD) begin
			xi_q <= '0;
			yi_q <= '0;
			s_q  <= '0;
			cs_q <= '0;
		end else begin
			if (st_q == ST_MAC) begin
				if (yi_q == kc - 2'd1) begin
					yi_q <= '0;
					xi_q <= xi_q + 2'd1;
				end else begin
					yi_q <= yi_q + 2'd1;
				end
			end
			if (pv_s1) begin
				s_q  <= s_q + nwc_pkg::SUM_W'(prod_s1);
				cs_q <= cs_q + nwc_pkg::CSUM_W'(cf_s1);
			end
		end

		prod_s1 <= $signed({1'b0, pix_sel}) * coef_sel;
		cf_s1   <= coef_sel;

		if (st_q == ST_CHK) begin
			val_q <= '0;
			dz_q  <= (cs_q == '0);
		end else if (st_q == ST_DIV && div_done) begin
			val_q <= div_quot;
		end

		if (res_load) begin
			res_q.value       <= val_q;
			res_q.div_by_zero <= dz_q;
			res_q.out_row     <= row_o;
			res_q.out_col     <= col_o[nwc_pkg::COL_W-1:0];
			res_q.last        <= (HW'(cur_r_q) == hc - HW'(1))
			                  && (WW'(cur_c_q) == wc - WW'(1));
		end
	end

endmodule

`default_nettype wire
